FILE: src/multi_slot_timer_queue_defines.svh
// Assertion macros used by the timer queue sequencer
`ifndef MULTI_SLOT_TIMER_QUEUE_DEFINES_SVH
`define MULTI_SLOT_TIMER_QUEUE_DEFINES_SVH

// Check an expression at every clock edge outside reset
`define MSTQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition is followed by another on the next edge
`define MSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mstq_pkg.sv
// Shared types and constants for the timer queue
`default_nettype none
package mstq_pkg;

  localparam int SLOT_W     = 4;
  localparam int WORD_W     = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-1:0] ADDR_SWITCH_ENABLE = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_SWITCH_SLOT   = 3'd4;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_CONFIG = 2'd1,
    FUNC_RUN    = 2'd2,
    FUNC_CANCEL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SCAN_COLLECT = 2'd0,
    SCAN_COUNT   = 2'd1,
    SCAN_DEC     = 2'd2
  } scan_mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SORT, S_LATCH, S_DECIDE, S_DSCAN, S_DISARM, S_WCFG,
    S_ASCAN, S_ARM, S_EMIT, S_COLLECT, S_LRD, S_LTGT, S_FREAD,
    S_FLATCH, S_FIRE, S_TOUT
  } state_t;

  typedef struct packed {
    logic       take;
    logic       latch_cur;
    logic       set_target_list;
    logic       scan_start;
    logic       scan_run;
    scan_mode_t scan_mode;
    logic       set_ign;
    logic       disarm;
    logic       write_cfg;
    logic       arm_write;
    logic       fire_note;
    logic       emit_plain;
    logic       emit_fire;
    logic       k_inc;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  slot_ok;
    logic  armed;
    logic  reload_ok;
    logic  repeat_on;
    logic  scan_done;
    logic  n_zero;
    logic  k_last;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/mstq_ctrl.sv
// Sequencer for the timer queue: decodes items and steps the datapath
`default_nettype none
`include "multi_slot_timer_queue_defines.svh"
module mstq_ctrl
  import mstq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_SORT;
      S_SORT:    state_next = (sts.func == FUNC_TICK) ? S_COLLECT : S_LATCH;
      S_LATCH:   state_next = S_DECIDE;
      S_DECIDE: begin
        case (sts.func)
          FUNC_CONFIG: begin
            if (!sts.slot_ok) state_next = S_EMIT;
            else if (sts.armed) state_next = S_DSCAN;
            else state_next = S_WCFG;
          end
          FUNC_RUN: begin
            if (sts.slot_ok && sts.reload_ok && !sts.armed) state_next = S_ASCAN;
            else state_next = S_EMIT;
          end
          FUNC_CANCEL: begin
            state_next = (sts.slot_ok && sts.armed) ? S_DSCAN : S_EMIT;
          end
          default:     state_next = S_EMIT;
        endcase
      end
      S_DSCAN: begin
        if (sts.scan_done) state_next = (sts.func == FUNC_CONFIG) ? S_WCFG : S_DISARM;
      end
      S_DISARM:  state_next = S_EMIT;
      S_WCFG:    state_next = S_EMIT;
      S_ASCAN:   if (sts.scan_done) state_next = S_ARM;
      S_ARM:     state_next = (sts.func == FUNC_TICK) ? S_TOUT : S_EMIT;
      S_EMIT:    if (sts.out_free) state_next = S_IDLE;
      S_COLLECT: if (sts.scan_done) state_next = sts.n_zero ? S_EMIT : S_LRD;
      S_LRD:     state_next = S_LTGT;
      S_LTGT:    state_next = S_FREAD;
      S_FREAD:   state_next = S_FLATCH;
      S_FLATCH:  state_next = S_FIRE;
      S_FIRE:    state_next = (sts.repeat_on && sts.reload_ok) ? S_ASCAN : S_TOUT;
      S_TOUT:    if (sts.out_free) state_next = sts.k_last ? S_IDLE : S_LRD;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.scan_mode = SCAN_COLLECT;
    case (state)
      S_IDLE:    cmd.take = 1'b1;
      S_SORT:    cmd.scan_start = 1'b1;
      S_LATCH:   cmd.latch_cur = 1'b1;
      S_DECIDE: begin
        cmd.scan_start = 1'b1;
        cmd.set_ign = (sts.func == FUNC_RUN) &&
                      !(sts.slot_ok && sts.reload_ok && !sts.armed);
      end
      S_DSCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_DEC;
      end
      S_DISARM:  cmd.disarm = 1'b1;
      S_WCFG:    cmd.write_cfg = 1'b1;
      S_ASCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_COUNT;
      end
      S_ARM:     cmd.arm_write = 1'b1;
      S_EMIT:    cmd.emit_plain = sts.out_free;
      S_COLLECT: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_COLLECT;
      end
      S_LTGT:    cmd.set_target_list = 1'b1;
      S_FLATCH:  cmd.latch_cur = 1'b1;
      S_FIRE: begin
        cmd.disarm     = 1'b1;
        cmd.fire_note  = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_TOUT: begin
        cmd.emit_fire = sts.out_free;
        cmd.k_inc     = sts.out_free;
      end
      default:   cmd = '0;
    endcase
  end

  `MSTQ_ASSERT_NEXT(a_accept_leaves_idle, cmd.take && in_valid, state == S_SORT, "no start")
  `MSTQ_ASSERT(a_emit_needs_room, !(cmd.emit_plain || cmd.emit_fire) || sts.out_free, "overrun")
  `MSTQ_ASSERT(a_list_not_empty, state != S_LRD || !sts.n_zero, "empty expiry list read")
  `MSTQ_ASSERT_NEXT(a_arm_after_count, state == S_ARM, state == S_TOUT || state == S_EMIT, "bad arm")

endmodule
`default_nettype wire

FILE: src/mstq_dpath.sv
// Slot storage, tick counter, scan unit and result register of the timer queue
`default_nettype none
module mstq_dpath
  import mstq_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_func,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [WORD_W-1:0] in_reload,
  input  wire logic              in_repeat,
  input  wire logic [WORD_W-1:0] in_event,
  input  wire logic              in_hasq,
  input  wire logic              switch_enable,
  input  wire logic [SLOT_W-1:0] switch_slot,
  input  wire logic              out_ready,
  output sts_t                   sts,
  output logic                   out_valid,
  output logic [SLOT_W-1:0]      fired_slot,
  output logic [WORD_W-1:0]      fired_data,
  output logic                   fired,
  output logic                   to_queue,
  output logic                   task_switch,
  output logic                   status,
  output logic [WORD_W-1:0]      tick_now,
  output logic                   last
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = IW + 1;

  logic [WORD_W-1:0] mem_reload   [NUM_SLOTS];
  logic [WORD_W-1:0] mem_payload  [NUM_SLOTS];
  logic              mem_repeat   [NUM_SLOTS];
  logic              mem_hasq     [NUM_SLOTS];
  logic [WORD_W-1:0] mem_deadline [NUM_SLOTS];
  logic [IW-1:0]     mem_order    [NUM_SLOTS];
  logic [IW-1:0]     list_mem     [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] slot_armed;
  logic [NUM_SLOTS-1:0] slot_conf;

  logic [WORD_W-1:0] tick_counter;
  func_t             item_func;
  logic [SLOT_W-1:0] item_slot;
  logic [WORD_W-1:0] item_reload;
  logic              item_repeat;
  logic [WORD_W-1:0] item_event;
  logic              item_hasq;

  logic [IW-1:0]     target;
  logic [WORD_W-1:0] rd_reload, rd_payload, rd_deadline;
  logic              rd_repeat, rd_hasq;
  logic [IW-1:0]     rd_order;
  logic [IW-1:0]     list_rdata;

  logic [WORD_W-1:0] cur_reload, cur_payload, cur_deadline;
  logic              cur_repeat, cur_hasq;
  logic [IW-1:0]     cur_order;

  logic [CW-1:0] scan_rd;
  logic          pv;
  logic [IW-1:0] pidx;
  logic [CW-1:0] cnt;
  logic [CW-1:0] n;
  logic [CW-1:0] k;
  logic          sw;
  logic          ign;

  logic              accept;
  logic [IW-1:0]     raddr;
  logic [WORD_W-1:0] ref_dl;
  logic              p_armed;
  logic              dec_we;
  logic              cnt_inc;
  logic              col_we;
  logic              k_last;

  assign accept  = cmd.take && in_valid;
  assign raddr   = cmd.scan_run ? scan_rd[IW-1:0] : target;
  assign ref_dl  = tick_counter + cur_reload;
  assign p_armed = slot_armed[pidx];
  assign dec_we  = cmd.scan_run && cmd.scan_mode == SCAN_DEC && pv && pidx != target &&
                   p_armed && rd_deadline == cur_deadline && rd_order > cur_order;
  assign cnt_inc = cmd.scan_run && cmd.scan_mode == SCAN_COUNT && pv && p_armed &&
                   rd_deadline == ref_dl;
  assign col_we  = cmd.scan_run && cmd.scan_mode == SCAN_COLLECT && pv && p_armed &&
                   rd_deadline == tick_counter;
  assign k_last  = (k + CW'(1)) == n;

  always_comb begin
    sts.func      = item_func;
    sts.slot_ok   = 32'(item_slot) < 32'(NUM_SLOTS);
    sts.armed     = slot_armed[target];
    sts.reload_ok = slot_conf[target] && cur_reload != '0;
    sts.repeat_on = cur_repeat;
    sts.scan_done = pv && pidx == IW'(NUM_SLOTS - 1);
    sts.n_zero    = n == '0;
    sts.k_last    = k_last;
    sts.out_free  = !out_valid || out_ready;
  end

  // hold the item, step the counter on a tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      item_func    <= FUNC_TICK;
    end else if (accept) begin
      item_func <= func_t'(in_func);
      if (func_t'(in_func) == FUNC_TICK) tick_counter <= tick_counter + WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_slot   <= in_slot;
      item_reload <= in_reload;
      item_repeat <= in_repeat;
      item_event  <= in_event;
      item_hasq   <= in_hasq;
      target      <= IW'(in_slot);
    end else if (cmd.set_target_list) begin
      target <= list_rdata;
    end
    if (cmd.latch_cur) begin
      cur_reload   <= rd_reload;
      cur_payload  <= rd_payload;
      cur_deadline <= rd_deadline;
      cur_repeat   <= rd_repeat;
      cur_hasq     <= rd_hasq;
      cur_order    <= rd_order;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_cfg) begin
      mem_reload[target]  <= item_reload;
      mem_payload[target] <= item_event;
      mem_repeat[target]  <= item_repeat;
      mem_hasq[target]    <= item_hasq;
    end
    if (cmd.arm_write) begin
      mem_deadline[target] <= ref_dl;
      mem_order[target]    <= cnt[IW-1:0];
    end else if (dec_we) begin
      mem_order[pidx] <= rd_order - IW'(1);
    end
    rd_reload   <= mem_reload[raddr];
    rd_payload  <= mem_payload[raddr];
    rd_repeat   <= mem_repeat[raddr];
    rd_hasq     <= mem_hasq[raddr];
    rd_deadline <= mem_deadline[raddr];
    rd_order    <= mem_order[raddr];
  end

  always_ff @(posedge clk) begin
    if (col_we) list_mem[rd_order] <= pidx;
    list_rdata <= list_mem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_armed <= '0;
      slot_conf  <= '0;
    end else if (cmd.write_cfg) begin
      slot_armed[target] <= 1'b0;
      slot_conf[target]  <= 1'b1;
    end else if (cmd.arm_write) begin
      slot_armed[target] <= 1'b1;
    end else if (cmd.disarm) begin
      slot_armed[target] <= 1'b0;
    end
  end

  // scan unit: one slot issued and one slot checked per cycle
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      scan_rd <= '0;
      pv      <= 1'b0;
      cnt     <= '0;
    end else begin
      pv   <= cmd.scan_run && scan_rd < CW'(NUM_SLOTS);
      pidx <= scan_rd[IW-1:0];
      if (cmd.scan_run && scan_rd < CW'(NUM_SLOTS)) scan_rd <= scan_rd + CW'(1);
      if (cnt_inc) cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || accept) begin
      n   <= '0;
      k   <= '0;
      sw  <= 1'b0;
      ign <= 1'b0;
    end else begin
      if (col_we) n <= n + CW'(1);
      if (cmd.k_inc) k <= k + CW'(1);
      if (cmd.set_ign) ign <= 1'b1;
      if (cmd.fire_note && !cur_hasq && switch_enable &&
          32'(target) == 32'(switch_slot)) sw <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_plain || cmd.emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_plain) begin
      fired_slot  <= '0;
      fired_data  <= '0;
      fired       <= 1'b0;
      to_queue    <= 1'b0;
      task_switch <= 1'b0;
      status      <= ign;
      tick_now    <= tick_counter;
      last        <= 1'b1;
    end else if (cmd.emit_fire) begin
      fired_slot  <= SLOT_W'(target);
      fired_data  <= cur_hasq ? cur_payload : '0;
      fired       <= 1'b1;
      to_queue    <= cur_hasq;
      task_switch <= k_last && sw;
      status      <= 1'b0;
      tick_now    <= tick_counter;
      last        <= k_last;
    end
  end

endmodule
`default_nettype wire

FILE: src/multi_slot_timer_queue.sv
// Top level of the timer queue: stream ports, register port, sequencer and datapath
//
//  channel  | dir | transfer on                      | contents
//  s_axis   | in  | s_axis_tvalid & s_axis_tready    | one tick, configure, run or cancel
//  m_axis   | out | m_axis_tvalid & m_axis_tready    | one result; tlast ends an item
//  apb      | in  | psel & penable & pwrite & pready | switch_enable, switch_slot
//
//  Configure, run, cancel: sort, latch, decide and emit, plus a write, arm or disarm
//  step when a slot is written, armed or disarmed, and a slot scan when one is disarmed or armed.
//  Tick: a deadline scan, then a plain result or, per expired slot, list read, target,
//  slot read, latch, fire and result, plus an interval re-arm scan for each reload.
//  Scans go through the slot memory one entry per cycle.
//  Reset clears counter and slot states at once; no clearing pass.
//  A stalled result holds the next one; a new item is taken while the last waits.
`default_nettype none
module multi_slot_timer_queue
  import mstq_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // slot[3:0], reload_count[35:4], repeat_mode[36], event_data[68:37],
  // has_destination[69], zero[71:70]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // fired_slot[3:0], fired_data[35:4], tick_now[67:36], zero[71:68]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // fired[0], to_queue[1], task_switch[2], status[3]
  output logic [3:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              switch_enable;
  logic [SLOT_W-1:0] switch_slot;
  logic [SLOT_W-1:0] fired_slot;
  logic [WORD_W-1:0] fired_data;
  logic [WORD_W-1:0] tick_now;
  logic              fired, to_queue, task_switch, status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_enable <= 1'b0;
      switch_slot   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == ADDR_SWITCH_ENABLE) switch_enable <= pwdata[0];
      if (paddr == ADDR_SWITCH_SLOT) switch_slot <= pwdata[SLOT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SWITCH_ENABLE) prdata = 32'(switch_enable);
    else if (paddr == ADDR_SWITCH_SLOT) prdata = 32'(switch_slot);
  end

  assign s_axis_tready = cmd.take;

  mstq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  mstq_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_valid      (s_axis_tvalid),
    .in_func       (s_axis_tuser),
    .in_slot       (s_axis_tdata[3:0]),
    .in_reload     (s_axis_tdata[35:4]),
    .in_repeat     (s_axis_tdata[36]),
    .in_event      (s_axis_tdata[68:37]),
    .in_hasq       (s_axis_tdata[69]),
    .switch_enable (switch_enable),
    .switch_slot   (switch_slot),
    .out_ready     (m_axis_tready),
    .sts           (sts),
    .out_valid     (m_axis_tvalid),
    .fired_slot    (fired_slot),
    .fired_data    (fired_data),
    .fired         (fired),
    .to_queue      (to_queue),
    .task_switch   (task_switch),
    .status        (status),
    .tick_now      (tick_now),
    .last          (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, tick_now, fired_data, fired_slot};
  assign m_axis_tuser = {status, task_switch, to_queue, fired};

endmodule
`default_nettype wire

FILE: dv/multi_slot_timer_queue_tb.sv
// Self-checking testbench for the multi-slot timer queue
`timescale 1ns / 1ps
module multi_slot_timer_queue_tb;
  import mstq_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [3:0]  slot;
    logic [31:0] data;
    logic        fired;
    logic        to_queue;
    logic        task_switch;
    logic        status;
    logic [31:0] tick_now;
    logic        last;
  } expiry_t;

  typedef enum logic [1:0] {
    SLOT_IDLE  = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_ARMED = 2'd2
  } slot_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multi_slot_timer_queue #(.NUM_SLOTS(NSLOT)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic        sw_enable;
  logic [3:0]  sw_slot;
  logic [31:0] ticks;
  slot_phase_t phase [NSLOT];
  logic [31:0] reload [NSLOT];
  logic        interval [NSLOT];
  logic [31:0] payload [NSLOT];
  logic        has_queue [NSLOT];
  logic [31:0] deadline [NSLOT];
  int          rank [NSLOT];

  expiry_t pending_results[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int fires_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic expiry_t plain_result(logic st);
    expiry_t r;
    r = '0;
    r.status = st;
    r.tick_now = ticks;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int peers_at(logic [31:0] dl);
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (phase[i] == SLOT_ARMED && deadline[i] == dl) n++;
    return n;
  endfunction

  function automatic void arm(int s);
    logic [31:0] dl;
    dl = ticks + reload[s];
    rank[s] = peers_at(dl);
    deadline[s] = dl;
    phase[s] = SLOT_ARMED;
  endfunction

  function automatic void disarm(int s);
    for (int i = 0; i < NSLOT; i++)
      if (i != s && phase[i] == SLOT_ARMED && deadline[i] == deadline[s] &&
          rank[i] > rank[s])
        rank[i]--;
    phase[s] = SLOT_READY;
    deadline[s] = '0;
    rank[s] = 0;
  endfunction

  function automatic void clear_timers();
    ticks = '0;
    for (int i = 0; i < NSLOT; i++) begin
      phase[i] = SLOT_IDLE;
      reload[i] = '0;
      interval[i] = 1'b0;
      payload[i] = '0;
      has_queue[i] = 1'b0;
      deadline[i] = '0;
      rank[i] = 0;
    end
  endfunction

  function automatic void predict_timers(func_t fn, logic [IN_DATA_W-1:0] d);
    int s;
    int due[$];
    expiry_t r;
    logic sw;
    s = int'(d[3:0]);
    case (fn)
      FUNC_TICK: begin
        ticks = ticks + 32'd1;
        sw = 1'b0;
        for (int o = 0; o < NSLOT; o++)
          for (int i = 0; i < NSLOT; i++)
            if (phase[i] == SLOT_ARMED && deadline[i] == ticks && rank[i] == o)
              due.push_back(i);
        if (due.size() == 0) pending_results.push_back(plain_result(1'b0));
        foreach (due[k]) begin
          int f;
          f = due[k];
          if (!has_queue[f] && sw_enable && f == int'(sw_slot)) sw = 1'b1;
          phase[f] = SLOT_READY;
          deadline[f] = '0;
          rank[f] = 0;
          if (interval[f] && reload[f] != 0) arm(f);
          r = '0;
          r.slot = 4'(f);
          r.data = has_queue[f] ? payload[f] : '0;
          r.fired = 1'b1;
          r.to_queue = has_queue[f];
          r.last = (k == due.size() - 1);
          r.task_switch = r.last && sw;
          r.tick_now = ticks;
          pending_results.push_back(r);
        end
      end
      FUNC_CONFIG: begin
        if (phase[s] == SLOT_ARMED) disarm(s);
        reload[s] = d[35:4];
        interval[s] = d[36];
        payload[s] = d[68:37];
        has_queue[s] = d[69];
        phase[s] = SLOT_READY;
        pending_results.push_back(plain_result(1'b0));
      end
      FUNC_RUN: begin
        if (reload[s] != 0 && phase[s] != SLOT_ARMED) begin
          arm(s);
          pending_results.push_back(plain_result(1'b0));
        end else begin
          pending_results.push_back(plain_result(1'b1));
        end
      end
      default: begin
        if (phase[s] == SLOT_ARMED) disarm(s);
        pending_results.push_back(plain_result(1'b0));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    expiry_t got;
    expiry_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.slot = m_axis_tdata[3:0];
      got.data = m_axis_tdata[35:4];
      got.tick_now = m_axis_tdata[67:36];
      got.fired = m_axis_tuser[0];
      got.to_queue = m_axis_tuser[1];
      got.task_switch = m_axis_tuser[2];
      got.status = m_axis_tuser[3];
      got.last = m_axis_tlast;
      received++;
      if (got.fired) fires_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result slot=%0d tick=%0d", got.slot, got.tick_now);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp slot=%0d data=%h fired=%b q=%b ts=%b st=%b tick=%0d last=%b",
              want.slot, want.data, want.fired, want.to_queue, want.task_switch,
              want.status, want.tick_now, want.last);
            $display("         got slot=%0d data=%h fired=%b q=%b ts=%b st=%b tick=%0d last=%b",
              got.slot, got.data, got.fired, got.to_queue, got.task_switch,
              got.status, got.tick_now, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(func_t fn, int s, logic [31:0] cnt = '0, logic rep = 1'b0,
                           logic [31:0] ev = '0, logic dest = 1'b0);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[3:0] = 4'(s);
    d[35:4] = cnt;
    d[36] = rep;
    d[68:37] = ev;
    d[69] = dest;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= fn;
    do @(posedge clk); while (!s_axis_tready);
    predict_timers(fn, d);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_SWITCH_ENABLE) sw_enable = value[0];
    else sw_slot = value[3:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    write_reg(ADDR_SWITCH_ENABLE, 32'd1);
    write_reg(ADDR_SWITCH_SLOT, 32'd15);
    send_item(FUNC_CONFIG, 0, 32'd1, 1'b0, 32'hA5A5_5A5A, 1'b1);
    send_item(FUNC_RUN, 0);
    send_item(FUNC_TICK, 0);
    send_item(FUNC_CONFIG, 3, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_RUN, 3);
    send_item(FUNC_RUN, 3);
    send_item(FUNC_RUN, 5);
    send_item(FUNC_CANCEL, 3);
    send_item(FUNC_CANCEL, 3);
    send_item(FUNC_CONFIG, 15, 32'd2, 1'b1, 32'h1234_5678, 1'b0);
    send_item(FUNC_CONFIG, 14, 32'd2, 1'b0, 32'h0000_0001, 1'b1);
    send_item(FUNC_RUN, 14);
    send_item(FUNC_RUN, 15);
    send_item(FUNC_CONFIG, 14, 32'd2, 1'b1, 32'h8000_0000, 1'b1);
    send_item(FUNC_RUN, 14);
    send_item(FUNC_TICK, 0);
    send_item(FUNC_TICK, 0);
    send_item(FUNC_TICK, 0);
    send_item(FUNC_TICK, 0);
    send_item(FUNC_CANCEL, 15);
    send_item(FUNC_CANCEL, 14);
    send_item(FUNC_TICK, 0);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    int pick;
    logic [31:0] cnt;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (k == n / 2) drain();
      if (pick < 40) send_item(FUNC_TICK, $urandom_range(15));
      else if (pick < 65) begin
        case ($urandom_range(9))
          0: cnt = '0;
          1: cnt = $urandom;
          default: cnt = $urandom_range(1, 5);
        endcase
        send_item(FUNC_CONFIG, $urandom_range(15), cnt, 1'($urandom_range(1)), $urandom,
                  1'($urandom_range(1)));
      end
      else if (pick < 90) send_item(FUNC_RUN, $urandom_range(15));
      else send_item(FUNC_CANCEL, $urandom_range(15));
    end
  endtask

  initial begin
    sw_enable = 1'b0;
    sw_slot = '0;
    clear_timers();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    write_reg(ADDR_SWITCH_SLOT, 32'd0);
    test_random(40, 0, 0);
    write_reg(ADDR_SWITCH_ENABLE, 32'd0);
    test_random(40, 59, 0);
    write_reg(ADDR_SWITCH_ENABLE, 32'd1);
    write_reg(ADDR_SWITCH_SLOT, 32'd7);
    test_random(45, 0, 59);
    write_reg(ADDR_SWITCH_SLOT, 32'd15);
    test_random(45, 29, 29);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    $display("sent %0d items, checked %0d results with %0d expiries", sent, received, fires_seen);
    $display("covered arming, interval reload, cancel, ignored runs and task-switch settings");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/mstq_pkg.sv
src/mstq_ctrl.sv
src/mstq_dpath.sv
src/multi_slot_timer_queue.sv
dv/multi_slot_timer_queue_tb.sv
